// ----- hw/rtl/rpl_pkg.sv -----
// Shared constants, status codes and controller/datapath interface types
// for the LRU page frame replacer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpl_pkg;

   localparam int FRAMES    = 16;
   localparam int PAGE_BITS = 16;
   localparam int AGE_BITS  = 16;

   localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int ACTIVE_W  = 5;
   localparam int PSIZE_W   = 17;
   localparam int PAGE_W    = 16;
   localparam int FRAME_W   = 4;
   localparam int ADDR_W    = 20;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_CNT_W = (PAGE_BITS > 1) ? $clog2(PAGE_BITS) : 1;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_HIT  = 2'd0;
   localparam status_type ST_FILL = 2'd1;
   localparam status_type ST_REPL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_FRAMES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SIZE     = 2'd1;

   typedef struct packed {
      logic load;
      logic scan;
      logic touch;
      logic div_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic div_done;
   } sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/rpl_ctrl.sv -----
// Sequencing state machine for the LRU page frame replacer.
// Depends on rpl_pkg; drives commands into rpl_dp and owns the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module rpl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire rpl_pkg::sts_type sts,
   output rpl_pkg::cmd_type      cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_TOUCH = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) state_in = S_TOUCH;
         end
         S_TOUCH: begin
            cmd.touch = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/rpl_dp.sv -----
// Datapath: configuration registers, frame table, scan, aging, remainder unit
// and result registers. Depends on rpl_pkg; driven by rpl_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module rpl_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rpl_pkg::cmd_type               cmd,
   output rpl_pkg::sts_type                    sts,
   input  wire logic                           csr_we,
   input  wire logic [rpl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rpl_pkg::PSIZE_W-1:0]    csr_data,
   input  wire logic [rpl_pkg::PAGE_W-1:0]     req_page,
   output rpl_pkg::status_type                 rsp_status,
   output logic [rpl_pkg::FRAME_W-1:0]         rsp_frame,
   output logic [rpl_pkg::ADDR_W-1:0]          rsp_phys_address
);

   localparam int IDX_W   = rpl_pkg::IDX_W;
   localparam int PB      = rpl_pkg::PAGE_BITS;
   localparam int AB      = rpl_pkg::AGE_BITS;
   localparam int PS_W    = rpl_pkg::PSIZE_W;
   localparam int AC_W    = rpl_pkg::ACTIVE_W;
   localparam int PROD_W  = IDX_W + PS_W;
   localparam logic [AB-1:0] AGE_MAX = {AB{1'b1}};

   // configuration
   logic [AC_W-1:0] active_ff;
   logic [PS_W-1:0] psize_ff;

   // frame table
   logic [PB-1:0]    fpage_ff  [rpl_pkg::FRAMES];
   logic [AB-1:0]    fage_ff   [rpl_pkg::FRAMES];
   logic [rpl_pkg::FRAMES-1:0] fvalid_ff;

   // request / scan
   logic [PB-1:0]       page_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [AB-1:0]       best_age_ff;
   logic [IDX_W-1:0]    chosen_ff;
   rpl_pkg::status_type status_ff;

   // remainder unit
   logic [PS_W-1:0]                 rem_ff;
   logic [PB-1:0]                   dvd_ff;
   logic [rpl_pkg::DIV_CNT_W-1:0]   div_cnt_ff;

   // result
   rpl_pkg::status_type             rsp_status_ff;
   logic [rpl_pkg::FRAME_W-1:0]     rsp_frame_ff;
   logic [rpl_pkg::ADDR_W-1:0]      rsp_addr_ff;

   logic [AC_W-1:0]  n_eff;
   logic [IDX_W-1:0] n_last;
   logic [PS_W-1:0]  psz;
   logic             cur_valid, cur_hit, cur_last, better;
   logic [AB-1:0]    cand_age;
   logic [IDX_W-1:0] cand_idx;
   logic [PS_W:0]    trial;
   logic [PS_W-1:0]  rem_in;
   logic [PROD_W-1:0] prod, sum;

   always_comb begin
      if (active_ff == '0)
         n_eff = AC_W'(1);
      else if (active_ff > AC_W'(rpl_pkg::FRAMES))
         n_eff = AC_W'(rpl_pkg::FRAMES);
      else
         n_eff = active_ff;
   end

   assign n_last = IDX_W'(n_eff - AC_W'(1));
   assign psz    = (psize_ff == '0) ? PS_W'(1) : psize_ff;

   assign cur_valid = fvalid_ff[idx_ff];
   assign cur_hit   = cur_valid && (fpage_ff[idx_ff] == page_ff);
   assign cur_last  = (idx_ff == n_last);
   assign better    = (idx_ff == '0) || (fage_ff[idx_ff] > best_age_ff);
   assign cand_age  = better ? fage_ff[idx_ff] : best_age_ff;
   assign cand_idx  = better ? idx_ff : best_idx_ff;

   assign sts.scan_done = !cur_valid || cur_hit || cur_last;
   assign sts.div_done  = (div_cnt_ff == rpl_pkg::DIV_CNT_W'(PB - 1));

   // restoring remainder step, one dividend bit per cycle
   assign trial  = {rem_ff, dvd_ff[PB-1]};
   assign rem_in = (trial >= {1'b0, psz}) ? PS_W'(trial - {1'b0, psz}) : PS_W'(trial);

   assign prod = PROD_W'(chosen_ff) * PROD_W'(psz);
   assign sum  = prod + PROD_W'(rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= AC_W'(16);
         psize_ff  <= PS_W'(4096);
         fvalid_ff <= '0;
         for (int j = 0; j < rpl_pkg::FRAMES; j++) fage_ff[j] <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rpl_pkg::CSR_ACTIVE_FRAMES: active_ff <= csr_data[AC_W-1:0];
               rpl_pkg::CSR_PAGE_SIZE:     psize_ff  <= csr_data;
               default: ;
            endcase
         end
         if (cmd.touch) begin
            fvalid_ff[chosen_ff] <= 1'b1;
            for (int j = 0; j < rpl_pkg::FRAMES; j++) begin
               if (j == int'(chosen_ff))
                  fage_ff[j] <= '0;
               else if (IDX_W'(j) <= n_last && fvalid_ff[j] && fage_ff[j] != AGE_MAX)
                  fage_ff[j] <= fage_ff[j] + AB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff    <= PB'(req_page);
         dvd_ff     <= PB'(req_page);
         rem_ff     <= '0;
         div_cnt_ff <= '0;
         idx_ff     <= '0;
      end
      if (cmd.scan) begin
         if (!cur_valid) begin
            status_ff <= rpl_pkg::ST_FILL;
            chosen_ff <= idx_ff;
         end else if (cur_hit) begin
            status_ff <= rpl_pkg::ST_HIT;
            chosen_ff <= idx_ff;
         end else if (cur_last) begin
            status_ff <= rpl_pkg::ST_REPL;
            chosen_ff <= cand_idx;
         end else begin
            best_age_ff <= cand_age;
            best_idx_ff <= cand_idx;
            idx_ff      <= idx_ff + IDX_W'(1);
         end
      end
      if (cmd.touch && status_ff != rpl_pkg::ST_HIT)
         fpage_ff[chosen_ff] <= page_ff;
      if (cmd.div_step) begin
         rem_ff     <= rem_in;
         dvd_ff     <= {dvd_ff[PB-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + rpl_pkg::DIV_CNT_W'(1);
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_frame_ff  <= rpl_pkg::FRAME_W'(chosen_ff);
         rsp_addr_ff   <= (status_ff == rpl_pkg::ST_REPL) ? '0 : sum[rpl_pkg::ADDR_W-1:0];
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_phys_address = rsp_addr_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/lru_page_frame_replacer.sv -----
// LRU page frame replacer.
//
// Channels: req_* carries one page number per request; rsp_* returns status
// (hit, filled empty frame, replaced oldest frame), the frame index and the
// physical address (frame * page_size + page mod page_size, zero on replace).
// csr_* writes active_frames (index 0) or page_size (index 1); csr_ready is
// always high; writes are to be made while no request is in flight, which
// the block itself does not enforce. Steps: accept, a scan of one frame at
// a time (1..active_frames frames), update, bit-serial remainder over the
// PAGE_BITS dividend bits, load of the result register. The frame scan and
// the bit-serial remainder unit dominate the response time.
// One request is processed at a time; req_ready is high only when idle.
// The result register decouples the sides: a new request is accepted while
// the previous result waits; a stalled receiver holds the next result in the
// datapath until the register frees up.
// Reset (synchronous): all frames empty, ages zero, active_frames 16,
// page_size 4096, no result pending.
// Depends on rpl_pkg, rpl_ctrl and rpl_dp.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_frame_replacer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [rpl_pkg::PAGE_W-1:0]     req_page,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [rpl_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rpl_pkg::FRAME_W-1:0]         rsp_frame,
   output logic [rpl_pkg::ADDR_W-1:0]          rsp_phys_address,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [rpl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rpl_pkg::PSIZE_W-1:0]    csr_data
);

   rpl_pkg::cmd_type cmd;
   rpl_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   rpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rpl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_page         (req_page),
      .rsp_status       (rsp_status),
      .rsp_frame        (rsp_frame),
      .rsp_phys_address (rsp_phys_address)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/rpl_checker.sv -----
// Port-level assertions for lru_page_frame_replacer and the bind that attaches them.
// Depends on rpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpl_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [rpl_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [rpl_pkg::FRAME_W-1:0]   rsp_frame,
   input wire logic [rpl_pkg::ADDR_W-1:0]    rsp_phys_address
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frame) && $stable(rsp_phys_address))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == rpl_pkg::ST_HIT || rsp_status == rpl_pkg::ST_FILL
         || rsp_status == rpl_pkg::ST_REPL))
      else $error("bad status code");

   a_repl_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rpl_pkg::ST_REPL |-> rsp_phys_address == '0)
      else $error("nonzero address on replace");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lru_page_frame_replacer rpl_checker u_rpl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_frame        (rsp_frame),
   .rsp_phys_address (rsp_phys_address)
);

`default_nettype wire
